### rtl/fpa_pkg.sv
package fpa_pkg;

  localparam int PIPE_LAT = 36;
  localparam int QUO_W = 33;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_MIN      = 4'd4,
    OP_MAX      = 4'd5,
    OP_INC      = 4'd6,
    OP_DEC      = 4'd7,
    OP_TO_INT   = 4'd8,
    OP_FROM_INT = 4'd9
  } op_t;

  typedef struct packed {
    logic [3:0]         opcode;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               a_less;
    logic               a_equal;
    logic               a_greater;
    logic               divide_by_zero;
    logic               saturated;
  } out_res_t;

  typedef struct packed {
    logic [31:0]      rem;
    logic [63:0]      num;
    logic [31:0]      den;
    logic [QUO_W-1:0] quo;
    logic             neg;
    logic             ovf;
    logic             is_div;
  } div_st_t;

  typedef struct packed {
    logic     vld;
    out_res_t res;
    div_st_t  dv;
  } pipe_t;

endpackage

### rtl/fpa_front.sv
module fpa_front #(
  parameter int FRAC_BITS = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             acc,
  input  fpa_pkg::in_req_t req,
  output fpa_pkg::pipe_t   pipe_out
);

  logic                s1_vld_r;
  logic [3:0]          s1_op_r;
  logic signed [63:0]  s1_prod_r;
  fpa_pkg::out_res_t   s1_res_r;
  fpa_pkg::div_st_t    s1_dv_r;
  fpa_pkg::pipe_t      pipe_r;

  fpa_pkg::out_res_t   res_nxt;
  fpa_pkg::div_st_t    dv_nxt;
  logic [31:0]         mag_a;
  logic [63:0]         mag_p;
  logic [63:0]         rnd_p;
  fpa_pkg::pipe_t      pipe_nxt;

  always_comb begin
    res_nxt = '0;
    res_nxt.a_less    = req.operand_a < req.operand_b;
    res_nxt.a_equal   = req.operand_a == req.operand_b;
    res_nxt.a_greater = req.operand_a > req.operand_b;
    case (req.opcode)
      fpa_pkg::OP_ADD:      res_nxt.value = req.operand_a + req.operand_b;
      fpa_pkg::OP_SUB:      res_nxt.value = req.operand_a - req.operand_b;
      fpa_pkg::OP_DIV:      res_nxt.divide_by_zero = req.operand_b == 32'sd0;
      fpa_pkg::OP_MIN:      res_nxt.value = res_nxt.a_less ? req.operand_a : req.operand_b;
      fpa_pkg::OP_MAX:
        res_nxt.value = res_nxt.a_greater ? req.operand_a : req.operand_b;
      fpa_pkg::OP_INC:      res_nxt.value = req.operand_a + 32'sd1;
      fpa_pkg::OP_DEC:      res_nxt.value = req.operand_a - 32'sd1;
      fpa_pkg::OP_TO_INT:   res_nxt.value = req.operand_a >>> FRAC_BITS;
      fpa_pkg::OP_FROM_INT: res_nxt.value = req.operand_a << FRAC_BITS;
      default:              res_nxt.value = '0;
    endcase

    mag_a = req.operand_a[31] ? 32'(-req.operand_a) : 32'(req.operand_a);
    dv_nxt = '0;
    dv_nxt.num    = {32'd0, mag_a} << FRAC_BITS;
    dv_nxt.den    = req.operand_b[31] ? 32'(-req.operand_b) : 32'(req.operand_b);
    dv_nxt.neg    = req.operand_a[31] ^ req.operand_b[31];
    dv_nxt.is_div = (req.opcode == fpa_pkg::OP_DIV) && (req.operand_b != 32'sd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    s1_op_r   <= req.opcode;
    s1_prod_r <= 64'(req.operand_a) * 64'(req.operand_b);
    s1_res_r  <= res_nxt;
    s1_dv_r   <= dv_nxt;
  end

  always_comb begin
    pipe_nxt = '0;
    pipe_nxt.vld = s1_vld_r;
    pipe_nxt.res = s1_res_r;
    pipe_nxt.dv  = s1_dv_r;
    pipe_nxt.dv.ovf = {1'b0, s1_dv_r.num[63:33]} >= s1_dv_r.den;
    pipe_nxt.dv.rem = {1'b0, s1_dv_r.num[63:33]};
    mag_p = s1_prod_r[63] ? 64'(-s1_prod_r) : 64'(s1_prod_r);
    rnd_p = (mag_p + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    if (s1_op_r == fpa_pkg::OP_MUL) begin
      if (s1_prod_r[63]) begin
        if (rnd_p > 64'h8000_0000) begin
          pipe_nxt.res.value     = 32'sh8000_0000;
          pipe_nxt.res.saturated = 1'b1;
        end else begin
          pipe_nxt.res.value = 32'(-rnd_p[31:0]);
        end
      end else begin
        if (rnd_p > 64'h7FFF_FFFF) begin
          pipe_nxt.res.value     = 32'sh7FFF_FFFF;
          pipe_nxt.res.saturated = 1'b1;
        end else begin
          pipe_nxt.res.value = rnd_p[31:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pipe_r.vld <= 1'b0;
    end else begin
      pipe_r.vld <= pipe_nxt.vld;
    end
    pipe_r.res <= pipe_nxt.res;
    pipe_r.dv  <= pipe_nxt.dv;
  end

  assign pipe_out = pipe_r;

endmodule

### rtl/fpa_div_step.sv
module fpa_div_step #(
  parameter int BIT = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  fpa_pkg::pipe_t pipe_in,
  output fpa_pkg::pipe_t pipe_out
);

  fpa_pkg::pipe_t pipe_r;
  fpa_pkg::pipe_t pipe_nxt;
  logic [32:0]    shifted;
  logic [32:0]    diff;
  logic           ge;

  always_comb begin
    shifted  = {pipe_in.dv.rem, pipe_in.dv.num[BIT]};
    diff     = shifted - {1'b0, pipe_in.dv.den};
    ge       = shifted >= {1'b0, pipe_in.dv.den};
    pipe_nxt = pipe_in;
    pipe_nxt.dv.rem      = ge ? diff[31:0] : shifted[31:0];
    pipe_nxt.dv.quo[BIT] = ge;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pipe_r.vld <= 1'b0;
    end else begin
      pipe_r.vld <= pipe_nxt.vld;
    end
    pipe_r.res <= pipe_nxt.res;
    pipe_r.dv  <= pipe_nxt.dv;
  end

  assign pipe_out = pipe_r;

endmodule

### rtl/fpa_back.sv
module fpa_back (
  input  logic              clk,
  input  logic              rst_n,
  input  fpa_pkg::pipe_t    pipe_in,
  output logic              out_valid,
  output fpa_pkg::out_res_t out_res
);

  logic              vld_r;
  fpa_pkg::out_res_t res_r;
  fpa_pkg::out_res_t res_nxt;
  logic [33:0]       rnd_q;

  always_comb begin
    res_nxt = pipe_in.res;
    rnd_q = {1'b0, pipe_in.dv.quo}
          + 34'(({pipe_in.dv.rem, 1'b0} >= {1'b0, pipe_in.dv.den}));
    if (pipe_in.dv.is_div) begin
      if (pipe_in.dv.neg) begin
        if (pipe_in.dv.ovf || rnd_q > 34'h0_8000_0000) begin
          res_nxt.value     = 32'sh8000_0000;
          res_nxt.saturated = 1'b1;
        end else begin
          res_nxt.value = 32'(-rnd_q[31:0]);
        end
      end else begin
        if (pipe_in.dv.ovf || rnd_q > 34'h0_7FFF_FFFF) begin
          res_nxt.value     = 32'sh7FFF_FFFF;
          res_nxt.saturated = 1'b1;
        end else begin
          res_nxt.value = rnd_q[31:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= pipe_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid = vld_r;
  assign out_res   = res_r;

endmodule

### rtl/fixed_point_alu_unit.sv
// Channel   Ports                     Direction  Handshake
// request   start, busy, in_req       in         taken when start is high and busy low
// result    out_valid, out_res        out        one-cycle strobe, always taken
//
// Every request passes from acceptance to its result strobe through two front stages,
// one stage per quotient bit of the 33-bit divider chain, and one output stage.
// A new request can be accepted in every cycle, so busy stays low.
// Reset is synchronous and clears only the valid bits of the pipeline.
// The receiver cannot stall, so the pipeline never holds.
module fixed_point_alu_unit #(
  parameter int FRAC_BITS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  fpa_pkg::in_req_t  in_req,
  output logic              out_valid,
  output fpa_pkg::out_res_t out_res
);

  fpa_pkg::pipe_t chain [fpa_pkg::QUO_W+1];

  assign busy = 1'b0;

  fpa_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (start && !busy),
    .req      (in_req),
    .pipe_out (chain[0])
  );

  for (genvar i = 0; i < fpa_pkg::QUO_W; i++) begin : g_div
    fpa_div_step #(
      .BIT (fpa_pkg::QUO_W - 1 - i)
    ) u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .pipe_in  (chain[i]),
      .pipe_out (chain[i+1])
    );
  end

  fpa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pipe_in   (chain[fpa_pkg::QUO_W]),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(fpa_pkg::PIPE_LAT) out_valid)
    else $error("request did not produce a result on time");

  a_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot({out_res.a_less, out_res.a_equal, out_res.a_greater}))
    else $error("compare flags inconsistent");

  a_dz: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.divide_by_zero) |-> (out_res.value == 32'sd0 && !out_res.saturated))
    else $error("divide by zero result malformed");

  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.saturated) |->
      (out_res.value == 32'sh7FFF_FFFF || out_res.value == 32'sh8000_0000))
    else $error("saturated result not at a limit");
`endif

endmodule

### bench/fixed_point_alu_unit_tb.sv
module fixed_point_alu_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 8;
  localparam int MAX_CYCLES = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  fpa_pkg::in_req_t in_req = '0;
  logic out_valid;
  fpa_pkg::out_res_t out_res;

  fpa_pkg::out_res_t expected_q[$];
  int fail_count = 0;
  int cycle_count = 0;

  fixed_point_alu_unit #(.FRAC_BITS(FRAC)) uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req(in_req), .out_valid(out_valid), .out_res(out_res)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [31:0] clamp32(bit neg, logic [63:0] mag, ref bit sat);
    if (!neg) begin
      if (mag > 64'h7FFF_FFFF) begin
        sat = 1'b1;
        return 32'h7FFF_FFFF;
      end
      return mag[31:0];
    end
    if (mag > 64'h8000_0000) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return 32'h0 - mag[31:0];
  endfunction

  function automatic fpa_pkg::out_res_t alu_result(fpa_pkg::in_req_t r);
    fpa_pkg::out_res_t res;
    logic signed [63:0] a, b, p;
    logic [63:0] m, num, den;
    logic [31:0] ua, ub, v;
    bit sat, dz;
    a = r.operand_a;
    b = r.operand_b;
    ua = r.operand_a;
    ub = r.operand_b;
    sat = 1'b0;
    dz = 1'b0;
    v = '0;
    case (r.opcode)
      fpa_pkg::OP_ADD: v = ua + ub;
      fpa_pkg::OP_SUB: v = ua - ub;
      fpa_pkg::OP_MUL: begin
        p = a * b;
        m = (p < 0) ? -p : p;
        m = (m + (64'd1 << (FRAC - 1))) >> FRAC;
        v = clamp32(p < 0, m, sat);
      end
      fpa_pkg::OP_DIV: begin
        if (b == 0) begin
          dz = 1'b1;
        end else begin
          num = ((a < 0) ? -a : a) << FRAC;
          den = (b < 0) ? -b : b;
          m = (num * 2 + den) / (den * 2);
          v = clamp32((a < 0) != (b < 0), m, sat);
        end
      end
      fpa_pkg::OP_MIN: v = (a < b) ? ua : ub;
      fpa_pkg::OP_MAX: v = (a > b) ? ua : ub;
      fpa_pkg::OP_INC: v = ua + 1;
      fpa_pkg::OP_DEC: v = ua - 1;
      fpa_pkg::OP_TO_INT: v = $signed(ua) >>> FRAC;
      fpa_pkg::OP_FROM_INT: v = ua << FRAC;
      default: v = '0;
    endcase
    res.value = v;
    res.a_less = a < b;
    res.a_equal = a == b;
    res.a_greater = a > b;
    res.divide_by_zero = dz;
    res.saturated = sat;
    return res;
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    fpa_pkg::out_res_t e;
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result %h", out_res);
        fail_count++;
      end else begin
        e = expected_q.pop_front();
        if (out_res.value !== e.value) begin
          $error("value expected %h actual %h", e.value, out_res.value);
          fail_count++;
        end
        if (out_res.a_less !== e.a_less) begin
          $error("a_less expected %b actual %b", e.a_less, out_res.a_less);
          fail_count++;
        end
        if (out_res.a_equal !== e.a_equal) begin
          $error("a_equal expected %b actual %b", e.a_equal, out_res.a_equal);
          fail_count++;
        end
        if (out_res.a_greater !== e.a_greater) begin
          $error("a_greater expected %b actual %b", e.a_greater, out_res.a_greater);
          fail_count++;
        end
        if (out_res.divide_by_zero !== e.divide_by_zero) begin
          $error("divide_by_zero expected %b actual %b", e.divide_by_zero,
                 out_res.divide_by_zero);
          fail_count++;
        end
        if (out_res.saturated !== e.saturated) begin
          $error("saturated expected %b actual %b", e.saturated, out_res.saturated);
          fail_count++;
        end
      end
    end
  end

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n != 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Drives one request; start stays high if the next request follows at once.
  task automatic send_request(logic [3:0] op, logic [31:0] a, logic [31:0] b, bit gaps);
    fpa_pkg::in_req_t r;
    r.opcode = op;
    r.operand_a = a;
    r.operand_b = b;
    start <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_q.push_back(alu_result(r));
    if (gaps && $urandom_range(0, 1)) begin
      idle_gap();
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 4095) - 2048;
      3: return 32'h0;
      4: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
      default: return $urandom();
    endcase
  endfunction

  task automatic test_directed();
    send_request(fpa_pkg::OP_ADD, 32'h7FFF_FFFF, 32'h1, 1'b0);
    send_request(fpa_pkg::OP_SUB, 32'h8000_0000, 32'h1, 1'b0);
    send_request(fpa_pkg::OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_request(fpa_pkg::OP_MUL, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    send_request(fpa_pkg::OP_MUL, 32'h0000_0180, 32'hFFFF_FF80, 1'b0);
    send_request(fpa_pkg::OP_MUL, 32'h0000_0001, 32'h0000_0080, 1'b0);
    send_request(fpa_pkg::OP_DIV, 32'h0000_0100, 32'h0, 1'b0);
    send_request(fpa_pkg::OP_DIV, 32'h7FFF_FFFF, 32'h0000_0001, 1'b0);
    send_request(fpa_pkg::OP_DIV, 32'h8000_0000, 32'h0000_0100, 1'b0);
    send_request(fpa_pkg::OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
    send_request(fpa_pkg::OP_DIV, 32'h0000_0001, 32'h0000_0200, 1'b0);
    send_request(fpa_pkg::OP_MIN, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    send_request(fpa_pkg::OP_MIN, 32'h5, 32'h5, 1'b0);
    send_request(fpa_pkg::OP_MAX, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    send_request(fpa_pkg::OP_INC, 32'h7FFF_FFFF, 32'h0, 1'b0);
    send_request(fpa_pkg::OP_DEC, 32'h8000_0000, 32'h0, 1'b0);
    send_request(fpa_pkg::OP_TO_INT, 32'hFFFF_FF01, 32'h0, 1'b0);
    send_request(fpa_pkg::OP_TO_INT, 32'h7FFF_FFFF, 32'h0, 1'b0);
    send_request(fpa_pkg::OP_FROM_INT, 32'h00FF_FFFF, 32'h0, 1'b0);
    send_request(fpa_pkg::OP_FROM_INT, 32'hFFFF_FFFF, 32'h0, 1'b0);
    send_request(4'd10, 32'h1, 32'h2, 1'b0);
    send_request(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    drain();
  endtask

  task automatic test_random(int count);
    logic [3:0] op;
    for (int i = 0; i < count; i++) begin
      op = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(10, 15))
                                        : 4'($urandom_range(0, 9));
      send_request(op, rand_operand(), rand_operand(), 1'b1);
      if (i == count / 2) drain();
    end
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(1000);
    repeat (fpa_pkg::PIPE_LAT + 10) @(posedge clk);
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
